>>> rtl/mtrg_pkg.sv
package mtrg_pkg;

    localparam logic [9:0]  WORDS        = 10'd624;
    localparam logic [9:0]  IDX_LAST     = 10'd623;
    localparam logic [9:0]  SHIFT_DIST   = 10'd397;
    localparam logic [31:0] TWIST_XOR    = 32'h9908_b0df;
    localparam logic [31:0] SEED_MULT    = 32'd1812433253;
    localparam logic [31:0] DEFAULT_SEED = 32'd5489;
    localparam logic [31:0] TEMPER_B     = 32'h9d2c_5680;
    localparam logic [31:0] TEMPER_C     = 32'hefc6_0000;

    localparam logic CMD_DRAW   = 1'b0;
    localparam logic CMD_RESEED = 1'b1;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_SEED_FIRST,
        OP_SEED_DFLT,
        OP_SEED_MUL,
        OP_SEED_ADD,
        OP_TW_PRIME,
        OP_TW_RD,
        OP_TW_WR,
        OP_DRAW_RD,
        OP_DRAW_OUT
    } t_dp_op;

    typedef struct packed {
        logic idx_last;
        logic pos_exhausted;
        logic out_busy;
    } t_dp_sts;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SEED_MUL,
        S_SEED_ADD,
        S_TW_PRIME,
        S_TW_RD,
        S_TW_WR,
        S_DRAW_RD,
        S_DRAW_OUT
    } t_state;

endpackage

>>> rtl/mtrg_ctrl.sv
module mtrg_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic             i_command,
    input  mtrg_pkg::t_dp_sts i_sts,
    output logic             o_stall,
    output mtrg_pkg::t_dp_op o_op
);
    import mtrg_pkg::*;

    t_state r_state, n_state;
    logic   r_seeded, n_seeded;
    logic   r_draw_pend, n_draw_pend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_seeded    <= 1'b0;
            r_draw_pend <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_seeded    <= n_seeded;
            r_draw_pend <= n_draw_pend;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_seeded    = r_seeded;
        n_draw_pend = r_draw_pend;
        o_op        = OP_NONE;
        o_stall     = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_command == CMD_RESEED) begin
                        o_op        = OP_SEED_FIRST;
                        n_seeded    = 1'b1;
                        n_draw_pend = 1'b0;
                        n_state     = S_SEED_MUL;
                    end else if (!r_seeded) begin
                        o_op        = OP_SEED_DFLT;
                        n_seeded    = 1'b1;
                        n_draw_pend = 1'b1;
                        n_state     = S_SEED_MUL;
                    end else if (i_sts.pos_exhausted) begin
                        o_op    = OP_TW_PRIME;
                        n_state = S_TW_RD;
                    end else begin
                        o_op    = OP_DRAW_RD;
                        n_state = S_DRAW_OUT;
                    end
                end
            end
            S_SEED_MUL: begin
                o_op    = OP_SEED_MUL;
                n_state = S_SEED_ADD;
            end
            S_SEED_ADD: begin
                o_op = OP_SEED_ADD;
                if (i_sts.idx_last) begin
                    n_state = r_draw_pend ? S_TW_PRIME : S_IDLE;
                end else begin
                    n_state = S_SEED_MUL;
                end
            end
            S_TW_PRIME: begin
                o_op    = OP_TW_PRIME;
                n_state = S_TW_RD;
            end
            S_TW_RD: begin
                o_op    = OP_TW_RD;
                n_state = S_TW_WR;
            end
            S_TW_WR: begin
                o_op    = OP_TW_WR;
                n_state = i_sts.idx_last ? S_DRAW_RD : S_TW_RD;
            end
            S_DRAW_RD: begin
                o_op    = OP_DRAW_RD;
                n_state = S_DRAW_OUT;
            end
            S_DRAW_OUT: begin
                if (!i_sts.out_busy) begin
                    o_op    = OP_DRAW_OUT;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/mtrg_datapath.sv
module mtrg_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mtrg_pkg::t_dp_op  i_op,
    input  logic [31:0]       i_seed,
    input  logic              i_stall,
    output mtrg_pkg::t_dp_sts o_sts,
    output logic              o_valid,
    output logic [30:0]       o_random_value
);
    import mtrg_pkg::*;

    logic [31:0] r_mem [0:623];

    logic [9:0]  r_idx, n_idx;
    logic [9:0]  r_pos, n_pos;
    logic [31:0] r_prev, n_prev;
    logic [31:0] r_prod, n_prod;
    logic [31:0] r_cur, n_cur;
    logic [31:0] r_rd_a, r_rd_b;
    logic        r_out_valid, n_out_valid;
    logic [30:0] r_out, n_out;

    logic        we, rd_en;
    logic [9:0]  wa, ra, rb;
    logic [31:0] wd;

    logic [9:0]  idx_next1;
    logic [10:0] sum_b;
    logic [9:0]  idx_far;
    logic [31:0] mul_in, mix, twisted;
    logic [31:0] y1, y2, y3, y4;

    always_comb begin
        idx_next1 = (r_idx == IDX_LAST) ? '0 : r_idx + 10'd1;
        sum_b     = {1'b0, r_idx} + {1'b0, SHIFT_DIST};
        if (sum_b >= {1'b0, WORDS}) begin
            sum_b = sum_b - {1'b0, WORDS};
        end
        idx_far = sum_b[9:0];

        mul_in  = r_prev ^ (r_prev >> 30);
        mix     = {r_cur[31], r_rd_a[30:0]};
        twisted = r_rd_b ^ {1'b0, mix[31:1]} ^ (r_rd_a[0] ? TWIST_XOR : 32'd0);

        y1 = r_rd_a ^ (r_rd_a >> 11);
        y2 = y1 ^ ((y1 << 7) & TEMPER_B);
        y3 = y2 ^ ((y2 << 15) & TEMPER_C);
        y4 = y3 ^ (y3 >> 18);
    end

    always_comb begin
        n_idx       = r_idx;
        n_pos       = r_pos;
        n_prev      = r_prev;
        n_prod      = r_prod;
        n_cur       = r_cur;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_stall;
        we          = 1'b0;
        wa          = r_idx;
        wd          = twisted;
        rd_en       = 1'b0;
        ra          = idx_next1;
        rb          = idx_far;
        unique case (i_op)
            OP_NONE: begin
            end
            OP_SEED_FIRST, OP_SEED_DFLT: begin
                we     = 1'b1;
                wa     = '0;
                wd     = (i_op == OP_SEED_FIRST) ? i_seed : DEFAULT_SEED;
                n_prev = wd;
                n_idx  = 10'd1;
                n_pos  = WORDS;
            end
            OP_SEED_MUL: begin
                n_prod = SEED_MULT * mul_in;
            end
            OP_SEED_ADD: begin
                we     = 1'b1;
                wd     = r_prod + {22'd0, r_idx};
                n_prev = wd;
                n_idx  = r_idx + 10'd1;
            end
            OP_TW_PRIME: begin
                rd_en = 1'b1;
                ra    = '0;
                n_idx = '0;
                n_pos = '0;
            end
            OP_TW_RD: begin
                rd_en = 1'b1;
                n_cur = r_rd_a;
            end
            OP_TW_WR: begin
                we    = 1'b1;
                n_idx = r_idx + 10'd1;
            end
            OP_DRAW_RD: begin
                rd_en = 1'b1;
                ra    = r_pos;
                n_pos = r_pos + 10'd1;
            end
            OP_DRAW_OUT: begin
                n_out       = y4[31:1];
                n_out_valid = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wa] <= wd;
        end
        if (rd_en) begin
            r_rd_a <= r_mem[ra];
            r_rd_b <= r_mem[rb];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= WORDS;
            r_out_valid <= 1'b0;
        end else begin
            r_pos       <= n_pos;
            r_out_valid <= n_out_valid;
        end
        r_idx  <= n_idx;
        r_prev <= n_prev;
        r_prod <= n_prod;
        r_cur  <= n_cur;
        r_out  <= n_out;
    end

    assign o_sts.idx_last      = (r_idx == IDX_LAST);
    assign o_sts.pos_exhausted = (r_pos >= WORDS);
    assign o_sts.out_busy      = r_out_valid && i_stall;
    assign o_valid             = r_out_valid;
    assign o_random_value      = r_out;

`ifndef SYNTH
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= WORDS)
        else $error("read position out of range");

    a_draw_has_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == OP_DRAW_RD) |-> !o_sts.pos_exhausted)
        else $error("draw read with exhausted state");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == OP_DRAW_OUT) |-> !o_sts.out_busy)
        else $error("result overwritten while stalled");

    a_out_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == OP_DRAW_OUT) |=> (r_out_valid && r_out == $past(y4[31:1])))
        else $error("result not loaded");

    a_twist_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == OP_TW_WR) |-> (r_idx <= IDX_LAST))
        else $error("twist index out of range");
`endif

endmodule

>>> rtl/mt19937_random_generator.sv
// MT19937 random number generator, 31-bit results.
// Input channel (i_valid / o_stall): each item is a reseed (i_command = 1,
// seed from i_seed) or a draw (i_command = 0). Output channel (o_valid /
// i_stall): one item per draw, none per reseed.
// Items are taken one at a time; o_stall is high while an item is in work.
// Draw from a fresh state word: the word is read from the state memory, then
// tempered into the output register; the next item can then be accepted.
// Draw that finds the 624-word state used up: the state is twisted word
// by word (two reads and one write on the state memory per word).
// Reseed: the seed recurrence runs word by word (multiply, then add and
// write) and gives no result.
// The first draw after reset, unless a reseed came first, seeds with 5489
// and then twists before the normal draw.
// Reset sets the read position to 624 (state used up) and clears the seeded
// and pending-draw flags, the output valid flag and the control state; the
// state memory is not cleared and is never read before a seeding fills it.
// When i_stall holds a result, o_random_value stays put; the next item can
// still be accepted and worked on, and its result waits until the output
// register is free.
module mt19937_random_generator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_command,
    input  logic [31:0] i_seed,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [30:0] o_random_value
);
    import mtrg_pkg::*;

    t_dp_op  op;
    t_dp_sts sts;

    mtrg_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_command (i_command),
        .i_sts     (sts),
        .o_stall   (o_stall),
        .o_op      (op)
    );

    mtrg_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_op           (op),
        .i_seed         (i_seed),
        .i_stall        (i_stall),
        .o_sts          (sts),
        .o_valid        (o_valid),
        .o_random_value (o_random_value)
    );

endmodule
